>>> hw/rtl/fir16s_pkg.sv
// Shared widths, codes and types for the scaled int16 FIR filter.
package fir16s_pkg;

   // Default number of taps in the delay line and coefficient store
   localparam int TAPS_DEFAULT = 16;

   // Field widths
   localparam int DATA_W      = 16;
   localparam int DIVIDER_W   = 15;
   localparam int ATAPS_W     = 5;
   localparam int COEF_IDX_W  = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Reset values of the configuration registers
   localparam logic [DIVIDER_W-1:0] DIVIDER_RESET     = DIVIDER_W'(1);
   localparam logic [ATAPS_W-1:0]   ACTIVE_TAPS_RESET = ATAPS_W'(16);

   // Request function codes
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_COEF   = 1'b1;

   // Register select (word address bit 2)
   localparam logic REG_DIVIDER     = 1'b0;
   localparam logic REG_ACTIVE_TAPS = 1'b1;

   // Divider result as seen by the sequencer
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> hw/rtl/fir16s_divider.sv
// Sequential signed-by-unsigned restoring divider, one quotient bit per cycle.
module fir16s_divider #(
   parameter int ACC_W = 36
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [ACC_W-1:0]              dividend,
   input  logic [fir16s_pkg::DIVIDER_W-1:0]     divisor,
   input  logic                                 take,
   output fir16s_pkg::div_rsp_type              rsp
);

   localparam int CNT_W = $clog2(ACC_W + 1);
   localparam int DW    = fir16s_pkg::DIVIDER_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [ACC_W-1:0]   quo_ff;
   logic [DW-1:0]      rem_ff;
   logic [DW-1:0]      div_ff;
   logic               neg_ff;
   logic [CNT_W-1:0]   cnt_ff;

   logic [ACC_W-1:0]   mag;
   logic [DW:0]        partial;
   logic [DW+1:0]      diff;
   logic               fits;
   logic [ACC_W-1:0]   signed_quo;

   // Magnitude of the dividend
   assign mag = dividend[ACC_W-1] ? (~dividend + ACC_W'(1)) : dividend;

   // Trial subtract of the shifted remainder
   assign partial = {rem_ff, quo_ff[ACC_W-1]};
   assign diff    = {1'b0, partial} - {2'b00, div_ff};
   assign fits    = !diff[DW+1];

   // Restore the sign, keep the low word
   assign signed_quo   = neg_ff ? (~quo_ff + ACC_W'(1)) : quo_ff;
   assign rsp.valid    = (state_ff == ST_DONE);
   assign rsp.quotient = signed_quo[fir16s_pkg::DATA_W-1:0];

   // Load, iterate, hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  quo_ff   <= mag;
                  rem_ff   <= '0;
                  div_ff   <= (divisor == '0) ? DW'(1) : divisor;
                  neg_ff   <= dividend[ACC_W-1];
                  cnt_ff   <= CNT_W'(ACC_W);
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               rem_ff <= fits ? diff[DW-1:0] : partial[DW-1:0];
               quo_ff <= {quo_ff[ACC_W-2:0], fits};
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

>>> hw/rtl/fir_filter_int16_scaled_core.sv
// Top level of the scaled int16 FIR filter: memories, MAC sequencer and register port.
//
//  channel | direction | handshake                        | payload
//  req     | in        | req_valid / req_ready            | func, sample, coef_index, coef_value
//  rsp     | out       | rsp_valid / rsp_ready            | filtered
//  csr     | in/out    | psel, penable, pwrite / pready   | paddr, pwdata, prdata
//
// A sample word walks the MAC pass (n = effective taps, one tap per cycle over the single
// read port of each memory), then the pipeline drains and the bit-serial divider runs; the
// next word is accepted only once the divider result has been taken and the sequencer is
// back to idle. A coefficient word is written when accepted and leaves the core idle.
// Reset clears the delay line and coefficients through per-entry valid bits, no sweep.
// A finished result waits in the output register while the next word is accepted; the
// divider holds its quotient if that register is still full.
module fir_filter_int16_scaled_core #(
   parameter int TAPS = fir16s_pkg::TAPS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_func,
   input  logic signed [fir16s_pkg::DATA_W-1:0]    req_sample,
   input  logic [fir16s_pkg::COEF_IDX_W-1:0]       req_coef_index,
   input  logic signed [fir16s_pkg::DATA_W-1:0]    req_coef_value,

   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [fir16s_pkg::DATA_W-1:0]    rsp_filtered,

   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [fir16s_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [fir16s_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [fir16s_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                    csr_pready
);

   localparam int DW    = fir16s_pkg::DATA_W;
   localparam int IDX_W = $clog2(TAPS);
   localparam int CNT_W = $clog2(TAPS + 1);
   localparam int ACC_W = 2 * DW + $clog2(TAPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_DIV
   } state_type;

   // Configuration registers
   logic [fir16s_pkg::DIVIDER_W-1:0]  divider_ff;
   logic [fir16s_pkg::ATAPS_W-1:0]    active_taps_ff;

   // Memories and their valid bits
   logic signed [DW-1:0]  dly_mem_ff  [TAPS];
   logic signed [DW-1:0]  coef_mem_ff [TAPS];
   logic [TAPS-1:0]       dly_vld_ff;
   logic [TAPS-1:0]       coef_vld_ff;
   logic signed [DW-1:0]  dly_rd_ff;
   logic signed [DW-1:0]  coef_rd_ff;
   logic                  dly_rv_ff;
   logic                  coef_rv_ff;

   // Sequencer and MAC pipeline
   state_type               state_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic signed [DW-1:0]    sample_ff;
   logic                    s1_vld_ff;
   logic [IDX_W-1:0]        s1_idx_ff;
   logic                    s2_vld_ff;
   logic signed [2*DW-1:0]  prod_ff;
   logic signed [ACC_W-1:0] acc_ff;

   // Output register
   logic                    rsp_valid_ff;
   logic signed [DW-1:0]    filtered_ff;

   logic                    req_fire;
   logic                    coef_we;
   logic [IDX_W-1:0]        coef_waddr;
   logic [IDX_W-1:0]        dly_raddr;
   logic [CNT_W-1:0]        eff_taps;
   logic signed [DW-1:0]    new_val;
   logic signed [DW-1:0]    coef_val;
   logic                    csr_wr;
   logic                    div_start;
   logic                    div_take;
   fir16s_pkg::div_rsp_type div_rsp;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = filtered_ff;
   assign csr_pready   = 1'b1;
   assign csr_wr       = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Read back the selected register
   always_comb begin
      unique case (csr_paddr[2])
         fir16s_pkg::REG_DIVIDER:
            csr_prdata = fir16s_pkg::CSR_DATA_W'(divider_ff);
         fir16s_pkg::REG_ACTIVE_TAPS:
            csr_prdata = fir16s_pkg::CSR_DATA_W'(active_taps_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff     <= fir16s_pkg::DIVIDER_RESET;
         active_taps_ff <= fir16s_pkg::ACTIVE_TAPS_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == fir16s_pkg::REG_DIVIDER) begin
            divider_ff <= csr_pwdata[fir16s_pkg::DIVIDER_W-1:0];
         end else begin
            active_taps_ff <= csr_pwdata[fir16s_pkg::ATAPS_W-1:0];
         end
      end
   end

   // Clamp the tap count to 1 .. TAPS
   always_comb begin
      if (active_taps_ff == '0) begin
         eff_taps = CNT_W'(1);
      end else if (int'(active_taps_ff) > TAPS) begin
         eff_taps = CNT_W'(TAPS);
      end else begin
         eff_taps = CNT_W'(active_taps_ff);
      end
   end

   // Coefficient write, drop indexes past the end of the store
   assign coef_waddr = IDX_W'(req_coef_index);
   assign coef_we    = req_fire && (req_func == fir16s_pkg::FUNC_COEF)
                       && (int'(req_coef_index) < TAPS);

   // Read slot idx-1 of the delay line; the slot below the write slot, never the same entry
   assign dly_raddr = idx_ff - IDX_W'(1);

   // Shifted value for slot s1_idx and its coefficient; unwritten entries read as zero
   assign new_val  = (s1_idx_ff == '0) ? sample_ff : (dly_rv_ff ? dly_rd_ff : '0);
   assign coef_val = coef_rv_ff ? coef_rd_ff : '0;

   // Delay line memory: write shifted value, registered read
   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         dly_mem_ff[s1_idx_ff] <= new_val;
      end
      dly_rd_ff <= dly_mem_ff[dly_raddr];
   end

   // Coefficient memory: write from requests, registered read
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem_ff[coef_waddr] <= req_coef_value;
      end
      coef_rd_ff <= coef_mem_ff[idx_ff];
   end

   // Valid bits stand in for the cleared reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         dly_vld_ff  <= '0;
         coef_vld_ff <= '0;
         dly_rv_ff   <= 1'b0;
         coef_rv_ff  <= 1'b0;
      end else begin
         if (s1_vld_ff) begin
            dly_vld_ff[s1_idx_ff] <= 1'b1;
         end
         if (coef_we) begin
            coef_vld_ff[coef_waddr] <= 1'b1;
         end
         dly_rv_ff  <= dly_vld_ff[dly_raddr];
         coef_rv_ff <= coef_vld_ff[idx_ff];
      end
   end

   // Divider handshake
   assign div_start = (state_ff == ST_DRAIN) && !s1_vld_ff && !s2_vld_ff;
   assign div_take  = (state_ff == ST_DIV) && div_rsp.valid && (!rsp_valid_ff || rsp_ready);

   fir16s_divider #(
      .ACC_W (ACC_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (divider_ff),
      .take     (div_take),
      .rsp      (div_rsp)
   );

   // Sequencer, MAC pipeline and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // advance the MAC pipeline
         s1_vld_ff <= (state_ff == ST_MAC);
         s1_idx_ff <= idx_ff;
         s2_vld_ff <= s1_vld_ff;
         prod_ff   <= (2*DW)'(new_val) * (2*DW)'(coef_val);
         if (s2_vld_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_func == fir16s_pkg::FUNC_SAMPLE)) begin
                  sample_ff <= req_sample;
                  idx_ff    <= IDX_W'(eff_taps - CNT_W'(1));
                  acc_ff    <= '0;
                  state_ff  <= ST_MAC;
               end
            end
            ST_MAC: begin
               // walk taps from the oldest down to the newest
               if (idx_ff == '0) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  idx_ff <= idx_ff - IDX_W'(1);
               end
            end
            ST_DRAIN: begin
               if (div_start) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // hold the result until taken
         if (div_take) begin
            rsp_valid_ff <= 1'b1;
            filtered_ff  <= div_rsp.quotient;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
